// File: rtl/msar_pkg.sv
// Shared constants, types and lookup tables of the Markov-switching AR filter.
package msar_pkg;

    localparam int MAX_REGIMES    = 4;
    localparam int MAX_REGRESSORS = 8;

    // Item kinds carried in the low bits of the input tuser
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_REGR   = 2'd1;
    localparam logic [1:0] OP_OBS    = 2'd2;
    localparam logic [1:0] OP_SERIES = 2'd3;

    // Table selectors for load items
    localparam logic [2:0] TSEL_COEF  = 3'd0;
    localparam logic [2:0] TSEL_MEAN  = 3'd1;
    localparam logic [2:0] TSEL_SIGMA = 3'd2;
    localparam logic [2:0] TSEL_TRANS = 3'd3;
    localparam logic [2:0] TSEL_INIT  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_REGIMES    = 2'd0;
    localparam logic [1:0] CFG_REGRESSORS = 2'd1;

    // Table memory layout
    localparam logic [5:0] ADDR_COEF  = 6'd0;
    localparam logic [5:0] ADDR_MEAN  = 6'd32;
    localparam logic [5:0] ADDR_SIGMA = 6'd36;
    localparam logic [5:0] ADDR_TRANS = 6'd40;
    localparam logic [5:0] ADDR_INIT  = 6'd56;
    localparam int         TBL_DEPTH  = 64;

    // Divider geometry: Q16.16 numerators up to 48 bits, sums up to 35 bits
    localparam int NUM_W     = 48;
    localparam int DEN_W     = 35;
    localparam int DIV_STEPS = NUM_W;

    localparam logic signed [63:0] HALF_LOG_TWO_PI = 64'sd60224;
    localparam logic signed [32:0] LN_TWO_Q        = 33'sd45426;
    localparam logic [30:0]        Q_MAX           = 31'h7FFFFFFF;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } div_rsp_t;

    // exp(-n) for integer n in Q16.16
    function automatic logic [16:0] exp_int_lut(input logic [3:0] n);
        logic [16:0] v;
        case (n)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-k/16) in Q16.16
    function automatic logic [16:0] exp_frac_lut(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd61565;
            5'd2:    v = 17'd57835;
            5'd3:    v = 17'd54331;
            5'd4:    v = 17'd51039;
            5'd5:    v = 17'd47947;
            5'd6:    v = 17'd45042;
            5'd7:    v = 17'd42313;
            5'd8:    v = 17'd39750;
            5'd9:    v = 17'd37341;
            5'd10:   v = 17'd35079;
            5'd11:   v = 17'd32954;
            5'd12:   v = 17'd30957;
            5'd13:   v = 17'd29081;
            5'd14:   v = 17'd27319;
            5'd15:   v = 17'd25664;
            5'd16:   v = 17'd24109;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // log2(1 + k/16) in Q16.16
    function automatic logic [16:0] log2_lut(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            5'd16:   v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh7FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sh80000000)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : v;
        return r;
    endfunction

    // Signed Q16.16 quotient from an unsigned quotient and the numerator sign
    function automatic logic signed [31:0] qdiv_fix(input logic neg,
                                                    input logic [NUM_W-1:0] quo);
        logic signed [31:0] r;
        if (neg)
            r = (quo > 48'h80000000) ? 32'sh80000000 : 32'(-quo[31:0]);
        else
            r = (quo > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : quo[31:0];
        return r;
    endfunction

endpackage

// File: rtl/msar_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module msar_div (
    input  logic               clk,
    input  logic               rst_n,
    input  msar_pkg::div_req_t req,
    output msar_pkg::div_rsp_t rsp
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [5:0]                   cnt_reg;
    logic [msar_pkg::NUM_W-1:0]   num_reg;
    logic [msar_pkg::DEN_W:0]     rem_reg;
    logic [msar_pkg::DEN_W-1:0]   den_reg;
    logic [msar_pkg::DEN_W:0]     rem_sh;
    logic                         ge;

    // Shift in the next numerator bit and trial-subtract
    always_comb
    begin
        rem_sh = {rem_reg[msar_pkg::DEN_W-1:0], num_reg[msar_pkg::NUM_W-1]};
        ge     = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= req.num;
                den_reg  <= req.den;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                num_reg <= {num_reg[msar_pkg::NUM_W-2:0], ge};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(msar_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;

endmodule

// File: rtl/markov_switching_ar_filter.sv
// Markov-switching AR filter: table memory, sequencer and output register.
// Load, regressor and new-series items are taken directly in the idle state.
// An observation runs through every one of the M regimes and K regressors,
// with three divisions per regime on the shared 48-step divider.
// One item is worked at a time; a result may wait in the output register.
// Reset: filtered probabilities zero, series not started, regimes 2, regressors 1.
module markov_switching_ar_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row_index[1:0], column_index[4:2], value[36:5]
    input  logic [4:0]  s_tuser,   // op[1:0], table_select[4:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // log_likelihood[31:0], best_regime[33:32]
    output logic        m_tuser,   // degenerate
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE, S_P_ISSUE, S_P_USE, S_P_ACC,
        S_R_SIG, S_R_SIGU, S_R_MEAN, S_R_MEANU, S_R_CISS, S_R_CMUL, S_R_CACC,
        S_R_ZDIV, S_R_ZWAIT, S_R_ZSQ, S_R_Q, S_R_RWAIT,
        S_W_BEGIN, S_W_E1, S_W_E2, S_W_E3, S_W_E4, S_W_E5, S_W_E6,
        S_N_CHECK, S_N_DIV, S_N_WAIT,
        S_L_SCAN, S_L_T1, S_L_T2, S_L_T3, S_L_T4, S_OUT
    } state_t;

    state_t state_reg;

    // Input fields
    logic [1:0]         in_op;
    logic [2:0]         in_sel;
    logic [1:0]         in_row;
    logic [2:0]         in_col;
    logic signed [31:0] in_value;
    logic               in_xfer;

    assign in_op    = s_tuser[1:0];
    assign in_sel   = s_tuser[4:2];
    assign in_row   = s_tdata[1:0];
    assign in_col   = s_tdata[4:2];
    assign in_value = s_tdata[36:5];
    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // Configuration registers
    logic [2:0] regimes_reg;
    logic [3:0] regressors_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regimes_reg    <= 3'd2;
            regressors_reg <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                msar_pkg::CFG_REGIMES:    regimes_reg    <= cfg_data[2:0];
                msar_pkg::CFG_REGRESSORS: regressors_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Table memory and regressor buffer
    logic [31:0] tbl_mem [msar_pkg::TBL_DEPTH];
    logic [31:0] tbl_rdata_reg;
    logic [5:0]  tbl_raddr;
    logic [5:0]  tbl_waddr;
    logic        tbl_we;
    logic signed [31:0] regbuf [msar_pkg::MAX_REGRESSORS];

    // Decode a load transfer into a table address
    always_comb
    begin
        tbl_we    = 1'b0;
        tbl_waddr = '0;
        unique case (in_sel)
            msar_pkg::TSEL_COEF:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = msar_pkg::ADDR_COEF + {1'b0, in_row, in_col};
            end
            msar_pkg::TSEL_MEAN:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = msar_pkg::ADDR_MEAN + {4'b0, in_row};
            end
            msar_pkg::TSEL_SIGMA:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = msar_pkg::ADDR_SIGMA + {4'b0, in_row};
            end
            msar_pkg::TSEL_TRANS:
            begin
                tbl_we    = !in_col[2];
                tbl_waddr = msar_pkg::ADDR_TRANS + {2'b0, in_row, in_col[1:0]};
            end
            msar_pkg::TSEL_INIT:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = msar_pkg::ADDR_INIT + {4'b0, in_row};
            end
            default: ;
        endcase
        tbl_we = tbl_we && in_xfer && (in_op == msar_pkg::OP_LOAD);
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_waddr] <= in_value;
        tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && (in_op == msar_pkg::OP_REGR))
            regbuf[in_col] <= in_value;
    end

    // Sequencer registers
    logic [2:0]         m_reg;
    logic [3:0]         k_reg;
    logic [1:0]         j_reg;
    logic [3:0]         i_reg;
    logic               started_reg;
    logic               deg_reg;
    logic signed [31:0] val_reg;
    logic signed [63:0] acc_reg;
    logic [31:0]        sm_reg;
    logic [30:0]        z_reg;
    logic [30:0]        qmin_reg;
    logic [1:0]         best_reg;
    logic signed [34:0] sum_reg;
    logic [3:0]         n_reg;
    logic [3:0]         fi_reg;
    logic [11:0]        t_reg;
    logic [16:0]        fr_reg;
    logic [16:0]        e_reg;
    logic [34:0]        norm_reg;
    logic [5:0]         p_reg;
    logic signed [23:0] x_reg;
    logic signed [31:0] ll_reg;
    logic signed [31:0] pred_reg [msar_pkg::MAX_REGIMES];
    logic [30:0]        q_reg    [msar_pkg::MAX_REGIMES];
    logic signed [31:0] r_reg    [msar_pkg::MAX_REGIMES];
    logic signed [31:0] a_reg    [msar_pkg::MAX_REGIMES];
    logic signed [31:0] filt_reg [msar_pkg::MAX_REGIMES];
    logic signed [65:0] prod_reg;
    logic               m_tvalid_reg;
    logic [39:0]        m_tdata_reg;
    logic               m_tuser_reg;

    // Shared multiplier operands
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [16:0]        frac_diff;
    logic [16:0]        log_diff;
    logic [3:0]         log_idx;

    assign log_idx   = norm_reg[33:30];
    assign frac_diff = msar_pkg::exp_frac_lut({1'b0, fi_reg})
                     - msar_pkg::exp_frac_lut({1'b0, fi_reg} + 5'd1);
    assign log_diff  = msar_pkg::log2_lut({1'b0, log_idx} + 5'd1)
                     - msar_pkg::log2_lut({1'b0, log_idx});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_P_USE:
            begin
                mul_a = {tbl_rdata_reg[31], tbl_rdata_reg};
                mul_b = {filt_reg[i_reg[1:0]][31], filt_reg[i_reg[1:0]]};
            end
            S_R_CMUL:
            begin
                mul_a = {tbl_rdata_reg[31], tbl_rdata_reg};
                mul_b = {regbuf[i_reg[2:0]][31], regbuf[i_reg[2:0]]};
            end
            S_R_ZSQ:
            begin
                mul_a = {2'b0, z_reg};
                mul_b = {2'b0, z_reg};
            end
            S_W_E1:
            begin
                mul_a = {16'b0, frac_diff};
                mul_b = {21'b0, t_reg};
            end
            S_W_E3:
            begin
                mul_a = {16'b0, msar_pkg::exp_int_lut(n_reg)};
                mul_b = {16'b0, fr_reg};
            end
            S_W_E5:
            begin
                mul_a = {r_reg[j_reg][31], r_reg[j_reg]};
                mul_b = {16'b0, e_reg};
            end
            S_L_T1:
            begin
                mul_a = {16'b0, log_diff};
                mul_b = {21'b0, norm_reg[29:18]};
            end
            S_L_T3:
            begin
                mul_a = {{9{x_reg[23]}}, x_reg};
                mul_b = msar_pkg::LN_TWO_Q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Table read address for the next cycle
    always_comb
    begin
        tbl_raddr = '0;
        case (state_reg)
            S_P_ISSUE:
                tbl_raddr = started_reg
                          ? msar_pkg::ADDR_TRANS + {2'b0, j_reg, i_reg[1:0]}
                          : msar_pkg::ADDR_INIT + {4'b0, j_reg};
            S_R_SIG:  tbl_raddr = msar_pkg::ADDR_SIGMA + {4'b0, j_reg};
            S_R_MEAN: tbl_raddr = msar_pkg::ADDR_MEAN + {4'b0, j_reg};
            S_R_CISS: tbl_raddr = msar_pkg::ADDR_COEF + {1'b0, j_reg, i_reg[2:0]};
            default: ;
        endcase
    end

    // Divider requests
    msar_pkg::div_req_t div_req;
    msar_pkg::div_rsp_t div_rsp;

    always_comb
    begin
        div_req = '0;
        case (state_reg)
            S_R_ZDIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = {msar_pkg::abs32(msar_pkg::sat32(acc_reg)), 16'b0};
                div_req.den   = {3'b0, sm_reg};
            end
            S_R_Q:
            begin
                div_req.start = 1'b1;
                div_req.num   = {msar_pkg::abs32(pred_reg[j_reg]), 16'b0};
                div_req.den   = {3'b0, sm_reg};
            end
            S_N_DIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = {msar_pkg::abs32(a_reg[j_reg]), 16'b0};
                div_req.den   = sum_reg;
            end
            default: ;
        endcase
    end

    msar_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Helper values for the sequencer
    logic               j_last;
    logic               i_last_m;
    logic               i_last_k;
    logic signed [63:0] prod_sh16;
    logic [31:0]        sig_mag;
    logic [30:0]        q_sq;
    logic [30:0]        q_diff;
    logic               q_better_sq;
    logic               q_better_max;
    logic [7:0]         p_off;
    logic [16:0]        lg_val;
    logic signed [63:0] ll_wide;

    assign j_last       = ({1'b0, j_reg} + 3'd1) == m_reg;
    assign i_last_m     = (i_reg + 4'd1) == {1'b0, m_reg};
    assign i_last_k     = (i_reg + 4'd1) == k_reg;
    assign prod_sh16    = {{14{prod_reg[65]}}, prod_reg[65:16]};
    assign sig_mag      = msar_pkg::abs32(tbl_rdata_reg);
    assign q_sq         = (prod_reg[65:48] != '0) ? msar_pkg::Q_MAX : prod_reg[47:17];
    assign q_diff       = q_reg[j_reg] - qmin_reg;
    assign q_better_sq  = (j_reg == 2'd0) || (q_sq < qmin_reg);
    assign q_better_max = (j_reg == 2'd0);
    assign p_off        = {2'b0, p_reg} - 8'd16;
    assign lg_val       = msar_pkg::log2_lut({1'b0, log_idx}) + prod_reg[28:12];
    assign ll_wide      = prod_sh16 - {33'b0, qmin_reg} - msar_pkg::HALF_LOG_TWO_PI;

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_reg        <= 3'd1;
            k_reg        <= '0;
            j_reg        <= '0;
            i_reg        <= '0;
            started_reg  <= 1'b0;
            deg_reg      <= 1'b0;
            val_reg      <= '0;
            acc_reg      <= '0;
            sm_reg       <= '0;
            z_reg        <= '0;
            qmin_reg     <= '0;
            best_reg     <= '0;
            sum_reg      <= '0;
            n_reg        <= '0;
            fi_reg       <= '0;
            t_reg        <= '0;
            fr_reg       <= '0;
            e_reg        <= '0;
            norm_reg     <= '0;
            p_reg        <= '0;
            x_reg        <= '0;
            ll_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
            for (int idx = 0; idx < msar_pkg::MAX_REGIMES; idx++)
            begin
                pred_reg[idx] <= '0;
                q_reg[idx]    <= '0;
                r_reg[idx]    <= '0;
                a_reg[idx]    <= '0;
                filt_reg[idx] <= '0;
            end
        end
        else
        begin
            // Drop the result once the consumer takes it, unless a new one replaces it
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT))
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (in_op == msar_pkg::OP_SERIES)
                            started_reg <= 1'b0;
                        else if (in_op == msar_pkg::OP_OBS)
                        begin
                            val_reg <= in_value;
                            m_reg   <= (regimes_reg == 3'd0) ? 3'd1
                                     : (regimes_reg > 3'(msar_pkg::MAX_REGIMES))
                                       ? 3'(msar_pkg::MAX_REGIMES) : regimes_reg;
                            k_reg   <= (regressors_reg > 4'(msar_pkg::MAX_REGRESSORS))
                                     ? 4'(msar_pkg::MAX_REGRESSORS) : regressors_reg;
                            j_reg   <= '0;
                            i_reg   <= '0;
                            acc_reg <= '0;
                            deg_reg <= 1'b0;
                            state_reg <= S_P_ISSUE;
                        end
                    end
                end

                // Predict regime probabilities
                S_P_ISSUE: state_reg <= S_P_USE;
                S_P_USE:
                begin
                    if (started_reg)
                        state_reg <= S_P_ACC;
                    else
                    begin
                        pred_reg[j_reg] <= tbl_rdata_reg;
                        if (j_last)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_R_SIG;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 2'd1;
                            state_reg <= S_P_ISSUE;
                        end
                    end
                end
                S_P_ACC:
                begin
                    if (i_last_m)
                    begin
                        pred_reg[j_reg] <= msar_pkg::sat32(acc_reg + prod_sh16);
                        acc_reg <= '0;
                        i_reg   <= '0;
                        if (j_last)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_R_SIG;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 2'd1;
                            state_reg <= S_P_ISSUE;
                        end
                    end
                    else
                    begin
                        acc_reg   <= acc_reg + prod_sh16;
                        i_reg     <= i_reg + 4'd1;
                        state_reg <= S_P_ISSUE;
                    end
                end

                // Scaled squared residual and ratio per regime
                S_R_SIG: state_reg <= S_R_SIGU;
                S_R_SIGU:
                begin
                    if (sig_mag == '0)
                    begin
                        deg_reg      <= 1'b1;
                        q_reg[j_reg] <= msar_pkg::Q_MAX;
                        r_reg[j_reg] <= '0;
                        if (q_better_max)
                        begin
                            qmin_reg <= msar_pkg::Q_MAX;
                            best_reg <= j_reg;
                        end
                        if (j_last)
                        begin
                            j_reg     <= '0;
                            sum_reg   <= '0;
                            state_reg <= S_W_BEGIN;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 2'd1;
                            state_reg <= S_R_SIG;
                        end
                    end
                    else
                    begin
                        sm_reg    <= sig_mag;
                        state_reg <= S_R_MEAN;
                    end
                end
                S_R_MEAN: state_reg <= S_R_MEANU;
                S_R_MEANU:
                begin
                    acc_reg   <= {{32{val_reg[31]}}, val_reg}
                               - {{32{tbl_rdata_reg[31]}}, tbl_rdata_reg};
                    i_reg     <= '0;
                    state_reg <= (k_reg == '0) ? S_R_ZDIV : S_R_CISS;
                end
                S_R_CISS: state_reg <= S_R_CMUL;
                S_R_CMUL: state_reg <= S_R_CACC;
                S_R_CACC:
                begin
                    acc_reg <= acc_reg - prod_sh16;
                    if (i_last_k)
                        state_reg <= S_R_ZDIV;
                    else
                    begin
                        i_reg     <= i_reg + 4'd1;
                        state_reg <= S_R_CISS;
                    end
                end
                S_R_ZDIV: state_reg <= S_R_ZWAIT;
                S_R_ZWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        z_reg <= (div_rsp.quo > {17'b0, msar_pkg::Q_MAX})
                               ? msar_pkg::Q_MAX : div_rsp.quo[30:0];
                        state_reg <= S_R_ZSQ;
                    end
                end
                S_R_ZSQ: state_reg <= S_R_Q;
                S_R_Q:
                begin
                    q_reg[j_reg] <= q_sq;
                    if (q_better_sq)
                    begin
                        qmin_reg <= q_sq;
                        best_reg <= j_reg;
                    end
                    state_reg <= S_R_RWAIT;
                end
                S_R_RWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        r_reg[j_reg] <= msar_pkg::qdiv_fix(pred_reg[j_reg][31], div_rsp.quo);
                        if (j_last)
                        begin
                            j_reg     <= '0;
                            sum_reg   <= '0;
                            state_reg <= S_W_BEGIN;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 2'd1;
                            state_reg <= S_R_SIG;
                        end
                    end
                end

                // Weight each regime against the best one
                S_W_BEGIN:
                begin
                    if (j_reg == best_reg || q_diff[30:16] >= 15'd12)
                    begin
                        if (j_reg == best_reg)
                        begin
                            a_reg[j_reg] <= r_reg[j_reg];
                            sum_reg <= sum_reg + {{3{r_reg[j_reg][31]}}, r_reg[j_reg]};
                        end
                        else
                            a_reg[j_reg] <= '0;
                        if (j_last)
                            state_reg <= S_N_CHECK;
                        else
                            j_reg <= j_reg + 2'd1;
                    end
                    else
                    begin
                        n_reg     <= q_diff[19:16];
                        fi_reg    <= q_diff[15:12];
                        t_reg     <= q_diff[11:0];
                        state_reg <= S_W_E1;
                    end
                end
                S_W_E1: state_reg <= S_W_E2;
                S_W_E2:
                begin
                    fr_reg    <= msar_pkg::exp_frac_lut({1'b0, fi_reg}) - prod_reg[28:12];
                    state_reg <= S_W_E3;
                end
                S_W_E3: state_reg <= S_W_E4;
                S_W_E4:
                begin
                    e_reg     <= prod_reg[32:16];
                    state_reg <= S_W_E5;
                end
                S_W_E5: state_reg <= S_W_E6;
                S_W_E6:
                begin
                    a_reg[j_reg] <= prod_reg[47:16];
                    sum_reg <= sum_reg + {{3{prod_reg[47]}}, prod_reg[47:16]};
                    if (j_last)
                        state_reg <= S_N_CHECK;
                    else
                    begin
                        j_reg     <= j_reg + 2'd1;
                        state_reg <= S_W_BEGIN;
                    end
                end

                // Normalize into filtered probabilities
                S_N_CHECK:
                begin
                    j_reg <= '0;
                    if (sum_reg[34] || sum_reg == '0)
                    begin
                        deg_reg   <= 1'b1;
                        ll_reg    <= 32'sh80000000;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        for (int idx = 0; idx < msar_pkg::MAX_REGIMES; idx++)
                        begin
                            if (3'(idx) >= m_reg)
                                filt_reg[idx] <= '0;
                        end
                        norm_reg  <= sum_reg;
                        p_reg     <= 6'd34;
                        state_reg <= S_N_DIV;
                    end
                end
                S_N_DIV: state_reg <= S_N_WAIT;
                S_N_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        filt_reg[j_reg] <= msar_pkg::qdiv_fix(a_reg[j_reg][31], div_rsp.quo);
                        if (j_last)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_L_SCAN;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 2'd1;
                            state_reg <= S_N_DIV;
                        end
                    end
                end

                // Natural log of the sum: find the leading one, then interpolate
                S_L_SCAN:
                begin
                    if (norm_reg[34])
                        state_reg <= S_L_T1;
                    else
                    begin
                        norm_reg <= {norm_reg[33:0], 1'b0};
                        p_reg    <= p_reg - 6'd1;
                    end
                end
                S_L_T1: state_reg <= S_L_T2;
                S_L_T2:
                begin
                    x_reg     <= {p_off, 16'b0} + {7'b0, lg_val};
                    state_reg <= S_L_T3;
                end
                S_L_T3: state_reg <= S_L_T4;
                S_L_T4:
                begin
                    ll_reg    <= msar_pkg::sat32(ll_wide);
                    state_reg <= S_OUT;
                end

                // Hand the result to the output register
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'b0, best_reg, ll_reg};
                        m_tuser_reg  <= deg_reg;
                        started_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    // A new result appears only when leaving the output state
    a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

    // Divider completions land only in a waiting state
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_R_ZWAIT || state_reg == S_R_RWAIT
                          || state_reg == S_N_WAIT))
        else $error("divider finished outside a wait state");

    // The regime counter stays within the active regimes while working
    a_regime_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> ({1'b0, j_reg} < m_reg))
        else $error("regime counter out of range");
`endif

endmodule

// File: sim/tb_markov_switching_ar_filter.sv
// Self-checking testbench of the Markov-switching AR filter with a scoreboard class.
`timescale 1ns / 1ps

module tb_markov_switching_ar_filter;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam longint     Q32_MAX   = 64'sd2147483647;
    localparam longint     Q32_MIN   = -64'sd2147483648;

    typedef struct {
        int       log_lik;
        bit [1:0] best;
        bit       degen;
    } filter_out_t;

    // Hamilton filter predictor plus the queue of pending outputs
    class filter_scoreboard;
        int unsigned regimes_cfg = 2;
        int unsigned regressors_cfg = 1;
        int coef[32];
        int means[4];
        int sigmas[4];
        int trans[16];
        int init_p[4];
        int filt[4];
        int regs[8];
        bit started;
        filter_out_t pending_q[$];
        int errors;
        int checked;
        int degen_seen;
        longint unsigned exp_int_t[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                            22, 8, 3, 1};
        longint unsigned exp_frac_t[17] = '{65536, 61565, 57835, 54331, 51039, 47947,
                                             45042, 42313, 39750, 37341, 35079, 32954,
                                             30957, 29081, 27319, 25664, 24109};
        longint unsigned log2_t[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312,
                                         38336, 42196, 45904, 49472, 52911, 56229, 59434,
                                         62534, 65536};

        function longint clamp32(longint v);
            if (v > Q32_MAX) return Q32_MAX;
            if (v < Q32_MIN) return Q32_MIN;
            return v;
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(-v) : v;
        endfunction

        function longint ratio_q(longint num, longint unsigned den);
            longint unsigned qq;
            qq = (mag(num) << 16) / den;
            if (num < 0)
                return qq > 64'h80000000 ? Q32_MIN : clamp32(-longint'(qq));
            return qq > 64'h7FFFFFFF ? Q32_MAX : longint'(qq);
        endfunction

        function longint unsigned decay(longint unsigned d);
            longint unsigned n, f, i, t, fr;
            if (d >= (64'd12 << 16)) return 0;
            n = d >> 16;
            f = d & 64'hFFFF;
            i = f >> 12;
            t = f & 64'hFFF;
            fr = exp_frac_t[i] - (((exp_frac_t[i] - exp_frac_t[i+1]) * t) >> 12);
            return (exp_int_t[n] * fr) >> 16;
        endfunction

        function longint nat_log(longint unsigned s);
            int p;
            longint unsigned mant, f, i, t, lg;
            p = 0;
            while (p < 63 && (s >> (p + 1)) != 0) p++;
            mant = p >= 16 ? s >> (p - 16) : s << (16 - p);
            f = mant & 64'hFFFF;
            i = f >> 12;
            t = f & 64'hFFF;
            lg = log2_t[i] + (((log2_t[i+1] - log2_t[i]) * t) >> 12);
            return ((longint'(p) - 16) * 65536 + longint'(lg)) * 45426 >>> 16;
        endfunction

        function void write_reg(logic [1:0] idx, logic [3:0] data);
            if (idx == msar_pkg::CFG_REGIMES) regimes_cfg = data & 4'h7;
            else if (idx == msar_pkg::CFG_REGRESSORS) regressors_cfg = data;
        endfunction

        // Run one filter step and queue its output
        function void filter_step(int y);
            int unsigned m, k, best;
            longint pred[4], q[4], r[4], a[4], qmin, sum, acc, ll;
            longint unsigned sm, z, zz;
            bit degen;
            filter_out_t res;
            degen = 0;
            sum = 0;
            best = 0;
            m = regimes_cfg == 0 ? 1 : (regimes_cfg > 4 ? 4 : regimes_cfg);
            k = regressors_cfg > 8 ? 8 : regressors_cfg;
            for (int j = 0; j < m; j++)
            begin
                if (started)
                begin
                    acc = 0;
                    for (int i = 0; i < m; i++)
                        acc += (longint'(trans[j*4+i]) * filt[i]) >>> 16;
                    pred[j] = clamp32(acc);
                end
                else
                    pred[j] = init_p[j];
            end
            for (int j = 0; j < m; j++)
            begin
                sm = mag(sigmas[j]);
                if (sm == 0)
                begin
                    degen = 1;
                    q[j] = Q32_MAX;
                    r[j] = 0;
                end
                else
                begin
                    acc = longint'(y) - means[j];
                    for (int i = 0; i < k; i++)
                        acc -= (longint'(coef[j*8+i]) * regs[i]) >>> 16;
                    z = (mag(clamp32(acc)) << 16) / sm;
                    if (z > 64'h7FFFFFFF) z = 64'h7FFFFFFF;
                    zz = (z * z) >> 17;
                    q[j] = zz > 64'h7FFFFFFF ? Q32_MAX : longint'(zz);
                    r[j] = ratio_q(pred[j], sm);
                end
            end
            qmin = q[0];
            for (int j = 1; j < m; j++)
                if (q[j] < qmin)
                begin
                    qmin = q[j];
                    best = j;
                end
            for (int j = 0; j < m; j++)
            begin
                if (j == best) a[j] = r[j];
                else a[j] = (r[j] * longint'(decay(q[j] - qmin))) >>> 16;
                sum += a[j];
            end
            if (sum <= 0)
            begin
                degen = 1;
                ll = Q32_MIN;
            end
            else
            begin
                for (int j = 0; j < 4; j++)
                    filt[j] = j < m ? int'(ratio_q(a[j], sum)) : 0;
                ll = nat_log(sum) - qmin - 60224;
            end
            started = 1;
            res.log_lik = int'(clamp32(ll));
            res.best = best[1:0];
            res.degen = degen;
            pending_q.push_back(res);
        endfunction

        // Apply one accepted input transfer
        function void note_input(logic [1:0] op, logic [2:0] sel, logic [1:0] row,
                                 logic [2:0] col, int val);
            case (op)
                msar_pkg::OP_LOAD:
                    case (sel)
                        msar_pkg::TSEL_COEF:  coef[row*8+col] = val;
                        msar_pkg::TSEL_MEAN:  means[row] = val;
                        msar_pkg::TSEL_SIGMA: sigmas[row] = val;
                        msar_pkg::TSEL_TRANS: if (col < 4) trans[row*4+col] = val;
                        msar_pkg::TSEL_INIT:  init_p[row] = val;
                        default: ;
                    endcase
                msar_pkg::OP_REGR:   regs[col] = val;
                msar_pkg::OP_SERIES: started = 0;
                default:             filter_step(val);
            endcase
        endfunction

        // Compare one output transfer with the oldest pending result
        function void check_result(int ll, logic [1:0] best, logic degen);
            filter_out_t e;
            if (pending_q.size() == 0)
            begin
                $error("unexpected output: log_likelihood %0d", ll);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (e.degen) degen_seen++;
            if (ll !== e.log_lik)
            begin
                $error("log_likelihood: expected %0d, got %0d", e.log_lik, ll);
                errors++;
            end
            if (best !== e.best)
            begin
                $error("best_regime: expected %0d, got %0d", e.best, best);
                errors++;
            end
            if (degen !== e.degen)
            begin
                $error("degenerate: expected %0d, got %0d", e.degen, degen);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // row_index[1:0], column_index[4:2], value[36:5]
    logic [4:0]  s_tuser;   // op[1:0], table_select[4:2]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // log_likelihood[31:0], best_regime[33:32]
    logic        m_tuser;   // degenerate
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_data;

    filter_scoreboard sb = new();
    bit burst;
    int hold_cycles;
    int cfg_writes;

    markov_switching_ar_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #300_000_000;
        $display("markov_switching_ar_filter verification failed");
        $finish;
    end

    // Output side: check transfers, draw idle gaps, honor long hold-offs
    initial
    begin
        int idle_left;
        idle_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata[31:0], m_tdata[33:32], m_tuser);
                idle_left = burst ? 0 : $urandom_range(0, 10);
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [2:0] sel,
                             input logic [1:0] row, input logic [2:0] col,
                             input logic [31:0] val);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {sel, op};
        s_tdata  <= {3'b0, val, col, row};
        do @(posedge clk); while (!s_tready);
        sb.note_input(op, sel, row, col, val);
    endtask

    task automatic load(input logic [2:0] sel, input logic [1:0] row,
                        input logic [2:0] col, input int val);
        send_item(msar_pkg::OP_LOAD, sel, row, col, val);
    endtask

    // Hold the input idle until all results are in, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending_q.size() != 0);
        repeat (800) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [3:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int signed_range(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // One random transfer, weighted toward well-formed model traffic
    task automatic random_item();
        int pick, j;
        logic [2:0] sel;
        int val;
        pick = $urandom_range(0, 99);
        j = $urandom_range(0, 3);
        if (pick < 40)
        begin
            if ($urandom_range(0, 19) == 0) val = $urandom;
            else val = sb.means[j] + signed_range(4 * 65536);
            send_item(msar_pkg::OP_OBS, 3'($urandom_range(0, 7)), 2'(j), 3'($urandom), val);
        end
        else if (pick < 65)
        begin
            val = $urandom_range(0, 19) == 0 ? int'($urandom) : signed_range(4 * 65536);
            send_item(msar_pkg::OP_REGR, 3'($urandom), 2'($urandom), 3'($urandom), val);
        end
        else if (pick < 95)
        begin
            sel = $urandom_range(0, 19) == 0 ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            case (sel)
                msar_pkg::TSEL_COEF:  val = signed_range(2 * 65536);
                msar_pkg::TSEL_MEAN:  val = signed_range(10 * 65536);
                msar_pkg::TSEL_SIGMA:
                begin
                    val = $urandom_range(0, 19) == 0 ? 0 : $urandom_range(16384, 4 * 65536);
                    if ($urandom_range(0, 9) == 0) val = -val;
                end
                default:    val = $urandom_range(0, 65536);
            endcase
            if ($urandom_range(0, 24) == 0) val = $urandom;
            load(sel, 2'($urandom), 3'($urandom), val);
        end
        else
            send_item(msar_pkg::OP_SERIES, 3'($urandom), 2'($urandom), 3'($urandom),
                      $urandom);
    endtask

    initial
    begin
        logic [3:0] regimes_set[7];
        logic [3:0] regressors_set[7];
        regimes_set    = '{4'd1, 4'd4, 4'd2, 4'd3, 4'd0, 4'd15, 4'd4};
        regressors_set = '{4'd0, 4'd8, 4'd1, 4'd5, 4'd15, 4'd3, 4'd8};
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        burst = 0;
        hold_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every table and regressor so no undefined entry is ever read
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 8; c++)
                load(msar_pkg::TSEL_COEF, 2'(r), 3'(c), signed_range(32768));
            for (int c = 0; c < 4; c++)
                load(msar_pkg::TSEL_TRANS, 2'(r), 3'(c), 16384);
            load(msar_pkg::TSEL_MEAN, 2'(r), 3'd0, r * 2 * 65536);
            load(msar_pkg::TSEL_SIGMA, 2'(r), 3'd0, (r + 1) * 65536);
            load(msar_pkg::TSEL_INIT, 2'(r), 3'd0, 16384);
        end
        for (int c = 0; c < 8; c++)
            send_item(msar_pkg::OP_REGR, 3'd0, 2'd0, 3'(c), signed_range(65536));

        // Directed: extremes, ignored loads, sigma sign, zero sigma, bad sums
        send_item(msar_pkg::OP_OBS, 3'd0, 2'd0, 3'd0, sb.means[0]);
        send_item(msar_pkg::OP_OBS, 3'd7, 2'd3, 3'd7, 32'h7FFFFFFF);
        send_item(msar_pkg::OP_OBS, 3'd0, 2'd0, 3'd0, 32'h80000000);
        send_item(msar_pkg::OP_SERIES, 3'd0, 2'd0, 3'd0, 0);
        send_item(msar_pkg::OP_OBS, 3'd0, 2'd0, 3'd0, 0);
        load(3'd5, 2'd0, 3'd0, 32'hFFFFFFFF);
        load(3'd7, 2'd3, 3'd7, 32'hFFFFFFFF);
        load(msar_pkg::TSEL_TRANS, 2'd0, 3'd5, 32'hFFFFFFFF);
        load(msar_pkg::TSEL_SIGMA, 2'd0, 3'd0, -65536);
        send_item(msar_pkg::OP_OBS, 3'd0, 2'd0, 3'd0, 65536);
        load(msar_pkg::TSEL_SIGMA, 2'd0, 3'd0, 0);
        send_item(msar_pkg::OP_OBS, 3'd0, 2'd0, 3'd0, 65536);
        load(msar_pkg::TSEL_SIGMA, 2'd1, 3'd0, 0);
        send_item(msar_pkg::OP_OBS, 3'd0, 2'd0, 3'd0, 65536);
        load(msar_pkg::TSEL_SIGMA, 2'd0, 3'd0, 65536);
        load(msar_pkg::TSEL_SIGMA, 2'd1, 3'd0, 2 * 65536);
        send_item(msar_pkg::OP_SERIES, 3'd0, 2'd0, 3'd0, 0);
        load(msar_pkg::TSEL_INIT, 2'd0, 3'd0, -65536);
        load(msar_pkg::TSEL_INIT, 2'd1, 3'd0, 0);
        send_item(msar_pkg::OP_OBS, 3'd0, 2'd0, 3'd0, 0);
        load(msar_pkg::TSEL_INIT, 2'd0, 3'd0, 32768);
        load(msar_pkg::TSEL_INIT, 2'd1, 3'd0, 32768);
        send_item(msar_pkg::OP_OBS, 3'd0, 2'd0, 3'd0, 131072);
        drain();
        write_cfg(CFG_SPARE, 4'hF);

        // Random phases over several settings, extremes included
        for (int ph = 0; ph < 7; ph++)
        begin
            write_cfg(msar_pkg::CFG_REGIMES, regimes_set[ph]);
            write_cfg(msar_pkg::CFG_REGRESSORS, regressors_set[ph]);
            burst = (ph == 4);
            if (ph == 2) hold_cycles = 3000;
            for (int n = 0; n < 240; n++)
                random_item();
            drain();
        end

        $display("checked %0d filter outputs (%0d degenerate) over %0d register writes",
                 sb.checked, sb.degen_seen, cfg_writes);
        if (sb.errors == 0)
            $display("markov_switching_ar_filter verification clean");
        else
            $display("markov_switching_ar_filter verification failed");
        $finish;
    end

endmodule
